// ===== rtl/core/multi_level_page_table_assert.svh =====
// ----------------------------------------------------------------------------
// multi_level_page_table assertion macros
// Concurrent check macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_LEVEL_PAGE_TABLE_ASSERT_SVH
`define MULTI_LEVEL_PAGE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define MLPT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MLPT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MLPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MLPT_ASSERT(lbl, clk, rst, prop, msg)
`define MLPT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MLPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/core/mlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpt_pkg
// Shared types and constants of the multi-level page table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlpt_pkg;

   localparam int ADDRESS_BITS = 32;
   localparam int MAX_LEVELS   = 4;
   localparam int LEVEL_W      = 2;
   localparam int ENTRY_DATA_W = 32;
   localparam int ENTRY_W      = ENTRY_DATA_W + 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;

   typedef logic [2:0] level_count_type;
   typedef logic [3:0] level_bits_type;
   typedef logic [4:0] vpn_bits_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_BITS_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_BITS_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_BITS_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_BITS_3 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VPN_BITS     = 3'd5;

   localparam level_count_type LEVEL_COUNT_RST  = 3'd2;
   localparam level_bits_type  LEVEL_BITS_0_RST = 4'd10;
   localparam level_bits_type  LEVEL_BITS_1_RST = 4'd10;
   localparam level_bits_type  LEVEL_BITS_2_RST = 4'd0;
   localparam level_bits_type  LEVEL_BITS_3_RST = 4'd0;
   localparam vpn_bits_type    VPN_BITS_RST     = 5'd20;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_ALLOC,
      ST_LEAF
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/mlpt_ram.sv =====
// ----------------------------------------------------------------------------
// mlpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlpt_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/multi_level_page_table.sv =====
// ----------------------------------------------------------------------------
// multi_level_page_table
// Radix page table: insert allocates nodes from a growing pool and maps the
// page to the next frame; lookup walks the levels and translates.
// ----------------------------------------------------------------------------
// After reset the node store is swept clear, one entry a cycle; busy stays
// high meanwhile and csr writes are still taken. A word is accepted when
// start is high and busy is low; its single response word appears on the
// rsp_ ports for one cycle with rsp_valid, in the first cycle with busy low
// again, and cannot be held off. Timing is set by the single node store and
// its registered read: each level visited passes an address state and then a
// read state. An insert walks to the first missing node, then allocates one
// node per alloc state and writes the leaf in a final leaf state. Running
// out of pool slots returns pool_full instead.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_level_page_table_assert.svh"

module multi_level_page_table #(
   parameter int POOL_SLOTS     = 65536,
   parameter int MAX_LEVEL_BITS = 12
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_command,
   input  wire logic [mlpt_pkg::ADDRESS_BITS-1:0]     req_virtual_address,
   output logic                                       rsp_valid,
   output logic                                       rsp_hit,
   output logic      [mlpt_pkg::ENTRY_DATA_W-1:0]     rsp_frame_number,
   output logic      [mlpt_pkg::ADDRESS_BITS-1:0]     rsp_physical_address,
   output logic                                       rsp_pool_full,
   input  wire logic                                  csr_write_enable,
   input  wire logic [mlpt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [mlpt_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   import mlpt_pkg::*;

   localparam int SLOT_W     = $clog2(POOL_SLOTS);
   localparam int FREE_W     = $clog2(POOL_SLOTS + 1);
   localparam int LB_W       = $clog2(MAX_LEVEL_BITS + 1);
   localparam int NEED_W     = MAX_LEVEL_BITS + 2;
   localparam int SUM_W      = ((FREE_W > NEED_W) ? FREE_W : NEED_W) + 1;
   localparam int SLOT_SUM_W = ENTRY_DATA_W + 1;
   localparam int ROOT_SLOTS = 2 ** MAX_LEVEL_BITS;
   localparam int OW_W       = $clog2(ADDRESS_BITS + 1);

   // configuration
   level_count_type cfg_level_count_ff;
   level_bits_type  cfg_level_bits_ff [MAX_LEVELS];
   vpn_bits_type    cfg_vpn_bits_ff;

   // sequencer state
   state_type                 state_ff, state_in;
   logic [SLOT_W-1:0]         clr_ff, clr_in;
   logic [FREE_W-1:0]         next_free_ff, next_free_in;
   logic [ENTRY_DATA_W-1:0]   next_frame_ff, next_frame_in;

   // item context
   logic                      cmd_ff, cmd_in;
   logic [ADDRESS_BITS-1:0]   va_ff, va_in;
   logic [ADDRESS_BITS-1:0]   vs_ff, vs_in;
   logic [ENTRY_DATA_W-1:0]   base_ff, base_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [LEVEL_W-1:0]        d_ff, d_in;
   logic [LEVEL_W-1:0]        last_ff, last_in;
   logic [LB_W-1:0]           bits_ff [MAX_LEVELS];
   logic [LB_W-1:0]           bits_in [MAX_LEVELS];

   // response
   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic [ENTRY_DATA_W-1:0]   rsp_frame_ff;
   logic [ADDRESS_BITS-1:0]   rsp_phys_ff;
   logic                      rsp_full_ff;
   logic                      fin;
   logic                      fin_hit;
   logic                      fin_full;
   logic [ENTRY_DATA_W-1:0]   fin_frame;
   logic [ADDRESS_BITS-1:0]   fin_phys;
   logic [OW_W-1:0]           ow;

   // shared index / slot unit
   logic [LEVEL_W-1:0]        d_next;
   logic [LEVEL_W-1:0]        sel_lvl;
   logic [LB_W-1:0]           sel_b;
   logic [MAX_LEVEL_BITS-1:0] idx_top;
   logic [MAX_LEVEL_BITS-1:0] idx;
   logic [SLOT_SUM_W-1:0]     base_sel;
   logic [SLOT_SUM_W-1:0]     slot_sum;
   logic                      slot_over;
   logic [NEED_W-1:0]         need;
   logic [SUM_W-1:0]          need_sum;
   logic                      pool_short;

   // node store
   logic                      ram_we;
   logic [SLOT_W-1:0]         ram_waddr;
   logic [ENTRY_W-1:0]        ram_wdata;
   logic [SLOT_W-1:0]         ram_raddr;
   logic [ENTRY_W-1:0]        ram_rdata;

   mlpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (POOL_SLOTS)
   ) u_node_store (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_level_count_ff   <= LEVEL_COUNT_RST;
         cfg_level_bits_ff[0] <= LEVEL_BITS_0_RST;
         cfg_level_bits_ff[1] <= LEVEL_BITS_1_RST;
         cfg_level_bits_ff[2] <= LEVEL_BITS_2_RST;
         cfg_level_bits_ff[3] <= LEVEL_BITS_3_RST;
         cfg_vpn_bits_ff      <= VPN_BITS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LEVEL_COUNT:  cfg_level_count_ff   <= csr_write_data[2:0];
            CSR_LEVEL_BITS_0: cfg_level_bits_ff[0] <= csr_write_data[3:0];
            CSR_LEVEL_BITS_1: cfg_level_bits_ff[1] <= csr_write_data[3:0];
            CSR_LEVEL_BITS_2: cfg_level_bits_ff[2] <= csr_write_data[3:0];
            CSR_LEVEL_BITS_3: cfg_level_bits_ff[3] <= csr_write_data[3:0];
            CSR_VPN_BITS:     cfg_vpn_bits_ff      <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         next_free_ff  <= FREE_W'(ROOT_SLOTS);
         next_frame_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         next_free_ff  <= next_free_in;
         next_frame_ff <= next_frame_in;
         rsp_valid_ff  <= fin;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      va_ff        <= va_in;
      vs_ff        <= vs_in;
      base_ff      <= base_in;
      slot_ff      <= slot_in;
      d_ff         <= d_in;
      last_ff      <= last_in;
      bits_ff      <= bits_in;
      rsp_hit_ff   <= fin_hit;
      rsp_frame_ff <= fin_frame;
      rsp_phys_ff  <= fin_phys;
      rsp_full_ff  <= fin_full;
   end

   // index of the selected level: top bits of the consumed-address register
   assign d_next   = d_ff + LEVEL_W'(1);
   assign sel_lvl  = (state_ff == ST_ALLOC) ? d_next : d_ff;
   assign sel_b    = bits_ff[sel_lvl];
   assign idx_top  = vs_ff[ADDRESS_BITS-1 -: MAX_LEVEL_BITS];
   assign idx      = idx_top >> (LB_W'(MAX_LEVEL_BITS) - sel_b);
   assign base_sel = (state_ff == ST_ALLOC) ? SLOT_SUM_W'(next_free_ff)
                                            : {1'b0, base_ff};
   assign slot_sum  = base_sel + SLOT_SUM_W'(idx);
   assign slot_over = (slot_sum >= SLOT_SUM_W'(POOL_SLOTS));

   always_comb begin
      need = '0;
      for (int k = 1; k < MAX_LEVELS; k++) begin
         if ((LEVEL_W'(k) > d_ff) && (LEVEL_W'(k) <= last_ff)) begin
            need = need + (NEED_W'(1) << bits_ff[k]);
         end
      end
   end

   assign need_sum   = SUM_W'(next_free_ff) + SUM_W'(need);
   assign pool_short = (need_sum > SUM_W'(POOL_SLOTS));

   assign ow       = OW_W'(ADDRESS_BITS) - OW_W'(cfg_vpn_bits_ff);
   assign fin_phys = fin_hit ? ((ADDRESS_BITS'(fin_frame) << ow)
                               | (va_ff & ~({ADDRESS_BITS{1'b1}} << ow)))
                             : '0;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      next_free_in  = next_free_ff;
      next_frame_in = next_frame_ff;
      cmd_in        = cmd_ff;
      va_in         = va_ff;
      vs_in         = vs_ff;
      base_in       = base_ff;
      slot_in       = slot_ff;
      d_in          = d_ff;
      last_in       = last_ff;
      bits_in       = bits_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_ff;
      ram_wdata     = '0;
      ram_raddr     = slot_sum[SLOT_W-1:0];
      fin           = 1'b0;
      fin_hit       = 1'b0;
      fin_full      = 1'b0;
      fin_frame     = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == SLOT_W'(POOL_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SLOT_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in  = req_command;
               va_in   = req_virtual_address;
               vs_in   = req_virtual_address;
               base_in = '0;
               d_in    = '0;
               if (cfg_level_count_ff == '0) begin
                  last_in = '0;
               end else if (cfg_level_count_ff > 3'(MAX_LEVELS)) begin
                  last_in = LEVEL_W'(MAX_LEVELS - 1);
               end else begin
                  last_in = LEVEL_W'(cfg_level_count_ff - 3'd1);
               end
               for (int k = 0; k < MAX_LEVELS; k++) begin
                  if (cfg_level_bits_ff[k] > MAX_LEVEL_BITS) begin
                     bits_in[k] = LB_W'(MAX_LEVEL_BITS);
                  end else begin
                     bits_in[k] = LB_W'(cfg_level_bits_ff[k]);
                  end
               end
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            if (slot_over) begin
               fin      = 1'b1;
               fin_full = cmd_ff;
               state_in = ST_IDLE;
            end else begin
               slot_in  = slot_sum[SLOT_W-1:0];
               vs_in    = vs_ff << sel_b;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (d_ff == last_ff) begin
               if (cmd_ff) begin
                  state_in = ST_LEAF;
               end else begin
                  fin      = 1'b1;
                  fin_hit  = ram_rdata[ENTRY_DATA_W];
                  fin_frame = ram_rdata[ENTRY_DATA_W] ? ram_rdata[ENTRY_DATA_W-1:0] : '0;
                  state_in = ST_IDLE;
               end
            end else if (ram_rdata[ENTRY_DATA_W]) begin
               base_in  = ram_rdata[ENTRY_DATA_W-1:0];
               d_in     = d_next;
               state_in = ST_ADDR;
            end else if (!cmd_ff) begin
               fin      = 1'b1;
               state_in = ST_IDLE;
            end else if (pool_short) begin
               fin      = 1'b1;
               fin_full = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            // link the current slot to a fresh node, step into it
            ram_we       = 1'b1;
            ram_wdata    = {1'b1, ENTRY_DATA_W'(next_free_ff)};
            next_free_in = next_free_ff + (FREE_W'(1) << sel_b);
            slot_in      = slot_sum[SLOT_W-1:0];
            vs_in        = vs_ff << sel_b;
            d_in         = d_next;
            if (d_next == last_ff) begin
               state_in = ST_LEAF;
            end
         end
         ST_LEAF: begin
            ram_we        = 1'b1;
            ram_wdata     = {1'b1, next_frame_ff};
            next_frame_in = next_frame_ff + ENTRY_DATA_W'(1);
            fin           = 1'b1;
            fin_hit       = 1'b1;
            fin_frame     = next_frame_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_frame_number     = rsp_frame_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_pool_full        = rsp_full_ff;

   `MLPT_ASSERT(a_pool_bound, clock, reset, next_free_ff <= FREE_W'(POOL_SLOTS), "pool pointer past end")
   `MLPT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `MLPT_ASSERT_IMP(a_frame_step, clock, reset, !$past(reset) && !$stable(next_frame_ff), rsp_valid && rsp_hit && !rsp_pool_full, "frame advanced without a hit insert")
   `MLPT_ASSERT_IMP(a_full_miss, clock, reset, rsp_valid && rsp_pool_full, !rsp_hit && (rsp_frame_number == '0), "pool full response reports a mapping")

endmodule

`default_nettype wire

// ===== tb/sv/multi_level_page_table_test.sv =====
// ----------------------------------------------------------------------------
// multi_level_page_table_test
// Self-checking bench for the radix page table. Lookup and insert words run
// through a series of table layouts, from the reset layout to the widest and
// narrowest ones. This drives the pool into exhaustion and reinterprets old
// trees. Each reply word is predicted from a private copy of the node pool
// and compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_level_page_table_test;

   import mlpt_pkg::*;

   localparam int POOL_DEPTH     = 65536;
   localparam int LEVEL_BITS_MAX = 12;
   localparam int ROOT_SLOTS     = 1 << LEVEL_BITS_MAX;
   localparam int QUIET_CYCLES   = 2 * MAX_LEVELS + 4;
   localparam int STALL_LIMIT    = 300000;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic        command;
      logic [31:0] address;
   } table_request_type;

   typedef struct packed {
      bit        hit;
      bit [31:0] frame_number;
      bit [31:0] physical_address;
      bit        pool_full;
   } table_reply_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_command = 1'b0;
   logic [ADDRESS_BITS-1:0]   req_virtual_address = '0;
   logic                      rsp_valid;
   logic                      rsp_hit;
   logic [ENTRY_DATA_W-1:0]   rsp_frame_number;
   logic [ADDRESS_BITS-1:0]   rsp_physical_address;
   logic                      rsp_pool_full;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;

   // predicted table state and layout
   bit [32:0]       node_mem [0:POOL_DEPTH-1];
   int unsigned     free_slot = ROOT_SLOTS;
   bit [31:0]       frame_ctr = '0;
   level_count_type cfg_levels = LEVEL_COUNT_RST;
   level_bits_type  cfg_bits [MAX_LEVELS] =
      '{LEVEL_BITS_0_RST, LEVEL_BITS_1_RST, LEVEL_BITS_2_RST, LEVEL_BITS_3_RST};
   vpn_bits_type    cfg_vpn = VPN_BITS_RST;

   table_request_type  pending_requests [$];
   table_reply_type    expected_replies [$];
   logic [31:0]        mapped_pages [$];

   table_request_type  next_request;
   table_reply_type    predicted_reply;
   table_reply_type    oldest_reply;
   int                 gap_cycles = 0;
   bit                 idle_bursts = 1'b1;
   int                 mismatch_count = 0;
   int                 stall_cycles = 0;

   multi_level_page_table #(
      .POOL_SLOTS     (POOL_DEPTH),
      .MAX_LEVEL_BITS (LEVEL_BITS_MAX)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_hit              (rsp_hit),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_physical_address (rsp_physical_address),
      .rsp_pool_full        (rsp_pool_full),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned effective_levels();
      int unsigned n;
      n = cfg_levels;
      if (n < 1) n = 1;
      if (n > MAX_LEVELS) n = MAX_LEVELS;
      return n;
   endfunction

   function automatic int unsigned level_width(input int unsigned k);
      int unsigned b;
      b = (k < MAX_LEVELS) ? cfg_bits[k] : 0;
      if (b > LEVEL_BITS_MAX) b = LEVEL_BITS_MAX;
      return b;
   endfunction

   // index bits of level k; bits past the bottom of the address read as zero
   function automatic int unsigned level_slice(input logic [31:0] va,
                                               input int unsigned k);
      int unsigned     cum, b, d, i;
      longint unsigned wide, m;
      wide = va;
      b = level_width(k);
      cum = 0;
      for (i = 0; i <= k; i++) cum += level_width(i);
      m = (64'd1 << b) - 64'd1;
      if (cum <= 32) return int'((wide >> (32 - cum)) & m);
      d = cum - 32;
      if (d >= b) return 0;
      return int'((wide << d) & m);
   endfunction

   // address bits below every level index
   function automatic logic [31:0] untranslated_mask();
      int unsigned used, k;
      used = 0;
      for (k = 0; k < effective_levels(); k++) used += level_width(k);
      if (used >= 32) return 32'd0;
      return (32'd1 << (32 - used)) - 32'd1;
   endfunction

   function automatic table_reply_type walk_table(input logic command,
                                                  input logic [31:0] va);
      table_reply_type r;
      int unsigned     levels, d, k, ow;
      longint unsigned base, slot, need, nb, wide;
      logic [31:0]     frame;
      bit              fail, reached, full, hit, stop;
      levels = effective_levels();
      base = 0;
      slot = 0;
      d = 0;
      frame = '0;
      fail = 1'b0;
      reached = 1'b0;
      full = 1'b0;
      hit = 1'b0;
      stop = 1'b0;
      while (!stop) begin
         slot = base + level_slice(va, d);
         if (slot >= POOL_DEPTH) begin
            fail = 1'b1;
            stop = 1'b1;
         end else if (d == levels - 1) begin
            reached = 1'b1;
            stop = 1'b1;
         end else if (!node_mem[slot][32]) begin
            stop = 1'b1;
         end else begin
            base = node_mem[slot][31:0];
            d++;
         end
      end
      if (command == CMD_LOOKUP) begin
         if (!fail && reached && node_mem[slot][32]) begin
            hit = 1'b1;
            frame = node_mem[slot][31:0];
         end
      end else if (fail) begin
         full = 1'b1;
      end else begin
         if (!reached) begin
            need = 0;
            for (k = d + 1; k < levels; k++) need += 64'd1 << level_width(k);
            if (longint'(free_slot) + need > POOL_DEPTH) begin
               full = 1'b1;
            end else begin
               for (k = d; k + 1 < levels; k++) begin
                  nb = free_slot;
                  free_slot += 1 << level_width(k + 1);
                  node_mem[slot] = {1'b1, nb[31:0]};
                  slot = nb + level_slice(va, k + 1);
               end
            end
         end
         if (!full) begin
            frame = frame_ctr;
            node_mem[slot] = {1'b1, frame};
            frame_ctr = frame_ctr + 32'd1;
            hit = 1'b1;
         end
      end
      r = '0;
      r.pool_full = full;
      if (hit) begin
         ow = 32 - cfg_vpn;
         wide = ({32'd0, frame} << ow) | ({32'd0, va} & ((64'd1 << ow) - 64'd1));
         r.hit = 1'b1;
         r.frame_number = frame;
         r.physical_address = wide[31:0];
      end
      return r;
   endfunction

   // driver: one word held on the req_ ports until taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_cycles <= 0;
      end else if (!(start && busy)) begin
         if (start) begin
            predicted_reply = walk_table(req_command, req_virtual_address);
            expected_replies.push_back(predicted_reply);
         end
         if (gap_cycles != 0) begin
            gap_cycles <= gap_cycles - 1;
            start <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            if (idle_bursts && $urandom_range(0, 5) == 0) begin
               gap_cycles <= $urandom_range(0, 7);
               start <= 1'b0;
            end else begin
               next_request = pending_requests.pop_front();
               start <= 1'b1;
               req_command <= next_request.command;
               req_virtual_address <= next_request.address;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_replies.size() == 0) begin
            $error("reply word with nothing expected");
            mismatch_count++;
         end else begin
            oldest_reply = expected_replies.pop_front();
            if (rsp_hit !== oldest_reply.hit) begin
               $error("hit: expected %0d actual %0d", oldest_reply.hit, rsp_hit);
               mismatch_count++;
            end
            if (rsp_frame_number !== oldest_reply.frame_number) begin
               $error("frame_number: expected %h actual %h",
                      oldest_reply.frame_number, rsp_frame_number);
               mismatch_count++;
            end
            if (rsp_physical_address !== oldest_reply.physical_address) begin
               $error("physical_address: expected %h actual %h",
                      oldest_reply.physical_address, rsp_physical_address);
               mismatch_count++;
            end
            if (rsp_pool_full !== oldest_reply.pool_full) begin
               $error("pool_full: expected %0d actual %0d",
                      oldest_reply.pool_full, rsp_pool_full);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("multi_level_page_table verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic queue_request(input logic command, input logic [31:0] va);
      table_request_type item;
      item.command = command;
      item.address = va;
      pending_requests.push_back(item);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         CSR_LEVEL_COUNT:  cfg_levels = data[2:0];
         CSR_LEVEL_BITS_0: cfg_bits[0] = data[3:0];
         CSR_LEVEL_BITS_1: cfg_bits[1] = data[3:0];
         CSR_LEVEL_BITS_2: cfg_bits[2] = data[3:0];
         CSR_LEVEL_BITS_3: cfg_bits[3] = data[3:0];
         CSR_VPN_BITS:     cfg_vpn = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [4:0] levels, input logic [4:0] b0,
                            input logic [4:0] b1, input logic [4:0] b2,
                            input logic [4:0] b3, input logic [4:0] vpn,
                            input bit spare);
      write_register(CSR_LEVEL_COUNT, levels);
      write_register(CSR_LEVEL_BITS_0, b0);
      write_register(CSR_LEVEL_BITS_1, b1);
      write_register(CSR_LEVEL_BITS_2, b2);
      write_register(CSR_LEVEL_BITS_3, b3);
      write_register(CSR_VPN_BITS, vpn);
      if (spare) begin
         write_register(CSR_SPARE_LO, 5'h1F);
         write_register(CSR_SPARE_HI, 5'h1F);
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly revisits of mapped pages; cluster_bits pins the top bits of
   // fresh addresses to a few values so the pool is not drained early
   task automatic add_random(input int count, input int cluster_bits);
      logic [31:0] seeds [4];
      logic [31:0] hi, va;
      logic        command;
      int          i;
      for (i = 0; i < 4; i++) seeds[i] = $urandom;
      hi = (cluster_bits == 0) ? 32'd0 : ~((32'd1 << (32 - cluster_bits)) - 32'd1);
      for (i = 0; i < count; i++) begin
         command = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
         if (mapped_pages.size() != 0 && $urandom_range(0, 99) < 55) begin
            va = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
            if ($urandom_range(0, 3) != 0) va = va ^ ($urandom & untranslated_mask());
         end else begin
            va = $urandom;
            va = (seeds[$urandom_range(0, 3)] & hi) | (va & ~hi);
         end
         if (command == CMD_INSERT) mapped_pages.push_back(va);
         queue_request(command, va);
      end
   endtask

   task automatic settle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_replies.size() != 0);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset layout: two levels of ten bits
      queue_request(CMD_INSERT, 32'h0000_0000);
      queue_request(CMD_LOOKUP, 32'h0000_0000);
      queue_request(CMD_LOOKUP, 32'h0000_0FFF);
      queue_request(CMD_LOOKUP, 32'hFFFF_FFFF);
      queue_request(CMD_INSERT, 32'hFFFF_FFFF);
      queue_request(CMD_LOOKUP, 32'hFFFF_FFFF);
      queue_request(CMD_INSERT, 32'h0000_0000);
      queue_request(CMD_LOOKUP, 32'h0000_0000);
      add_random(200, 10);
      settle();

      // four levels, narrow inner nodes, one page bit; spare indexes ignored
      configure(5'd4, 5'd12, 5'd2, 5'd2, 5'd2, 5'd1, 1'b1);
      add_random(300, 0);
      settle();

      // zero levels act as one, oversized root width clamps
      configure(5'd0, 5'd15, 5'd0, 5'd12, 5'd12, 5'd31, 1'b0);
      queue_request(CMD_INSERT, 32'hABC0_0000);
      queue_request(CMD_LOOKUP, 32'hABC0_0001);
      queue_request(CMD_LOOKUP, 32'h0000_0000);
      add_random(150, 0);
      settle();

      // single-entry middle level
      configure(5'd3, 5'd1, 5'd0, 5'd4, 5'd9, 5'd5, 1'b0);
      queue_request(CMD_INSERT, 32'h8000_0000);
      queue_request(CMD_LOOKUP, 32'h8000_0000);
      queue_request(CMD_LOOKUP, 32'h7FFF_FFFF);
      add_random(200, 0);
      settle();

      configure(5'd4, 5'd8, 5'd8, 5'd8, 5'd8, 5'd24, 1'b0);
      add_random(150, 16);
      settle();

      // clamped count and widths, indices past the address, no page bits;
      // big nodes run the pool dry
      configure(5'd7, 5'd13, 5'd13, 5'd13, 5'd0, 5'd0, 1'b0);
      queue_request(CMD_INSERT, 32'hFFFF_FFFF);
      queue_request(CMD_LOOKUP, 32'hFFFF_FFFF);
      queue_request(CMD_INSERT, 32'h1234_5678);
      queue_request(CMD_LOOKUP, 32'h1234_5678);
      add_random(300, 0);
      settle();

      idle_bursts = 1'b0;
      configure(5'd2, 5'd0, 5'd12, 5'd5, 5'd5, 5'd12, 1'b0);
      add_random(250, 0);
      settle();

      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("multi_level_page_table verification clean");
      end else begin
         $display("multi_level_page_table verification failed");
      end
      $finish;
   end

endmodule
